### design/tked_pkg.sv
package tked_pkg;

  // byte constants of the escape grammar
  localparam logic [7:0] ChEsc      = 8'h1b;
  localparam logic [7:0] ChLBracket = 8'h5b;
  localparam logic [7:0] ChTilde    = 8'h7e;
  localparam logic [7:0] ChSemi     = 8'h3b;
  localparam logic [7:0] ChFive     = 8'h35;
  localparam logic [7:0] ChThree    = 8'h33;
  localparam logic [7:0] ChOne      = 8'h31;
  localparam logic [7:0] ChZero     = 8'h30;
  localparam logic [7:0] ChNine     = 8'h39;
  localparam logic [7:0] ChUpperA   = 8'h41;
  localparam logic [7:0] ChUpperB   = 8'h42;
  localparam logic [7:0] ChUpperC   = 8'h43;
  localparam logic [7:0] ChUpperD   = 8'h44;

  // offset from a plain arrow class to its ctrl variant
  localparam logic [3:0] CtrlOffset = 4'd5;

  // word kinds on the input side
  typedef enum logic {
    OP_BYTE    = 1'b0,
    OP_TIMEOUT = 1'b1
  } opcode_e;

  // decoded key classes
  typedef enum logic [3:0] {
    KC_PLAIN      = 4'd0,
    KC_LEFT       = 4'd1,
    KC_RIGHT      = 4'd2,
    KC_UP         = 4'd3,
    KC_DOWN       = 4'd4,
    KC_DELETE     = 4'd5,
    KC_CTRL_LEFT  = 4'd6,
    KC_CTRL_RIGHT = 4'd7,
    KC_CTRL_UP    = 4'd8,
    KC_CTRL_DOWN  = 4'd9
  } key_class_e;

  // parser phases
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_ESC    = 3'd1,
    PH_SECOND = 3'd2,
    PH_THIRD  = 3'd3,
    PH_FOURTH = 3'd4,
    PH_FINAL  = 3'd5,
    PH_TILDE  = 3'd6
  } phase_e;

  // parser state
  typedef struct packed {
    phase_e phase;
    logic   first_was_bracket;
    logic   saw_semicolon;
    logic   digit_was_three;
  } parse_state_t;

  // one decoded key, valid when a word produces a result
  typedef struct packed {
    logic       valid;
    key_class_e key_class;
    logic [7:0] key_byte;
  } key_result_t;

  // final letters A..D map to up, down, right, left; anything else is plain
  function automatic key_class_e arrow_of(input logic [7:0] b);
    key_class_e k;
    unique case (b)
      ChUpperA: k = KC_UP;
      ChUpperB: k = KC_DOWN;
      ChUpperC: k = KC_RIGHT;
      ChUpperD: k = KC_LEFT;
      default:  k = KC_PLAIN;
    endcase
    return k;
  endfunction

endpackage

### design/tked_parser.sv
module tked_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  tked_pkg::opcode_e     opcode_i,
  input  logic [7:0]            byte_i,
  output tked_pkg::key_result_t result_o,
  output tked_pkg::parse_state_t state_o
);
  import tked_pkg::*;

  parse_state_t state_q, state_d;
  key_result_t  res;
  key_class_e   arrow;

  assign arrow = arrow_of(byte_i);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_IDLE, first_was_bracket: 1'b0,
                   saw_semicolon: 1'b0, digit_was_three: 1'b0};
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

  // next state and key for the word in hand
  always_comb begin
    parse_state_t idle_st;
    key_result_t  lone_esc;
    idle_st  = '{phase: PH_IDLE, first_was_bracket: 1'b0,
                 saw_semicolon: 1'b0, digit_was_three: 1'b0};
    lone_esc = '{valid: 1'b1, key_class: KC_PLAIN, key_byte: ChEsc};
    state_d  = state_q;
    res      = '{valid: 1'b0, key_class: KC_PLAIN, key_byte: 8'd0};

    if (state_q.phase == PH_IDLE || state_q.phase > PH_TILDE) begin
      // idle: timeouts are ignored, ESC opens a sequence
      if (opcode_i == OP_BYTE) begin
        state_d = idle_st;
        if (byte_i == ChEsc) begin
          state_d.phase = PH_ESC;
        end else begin
          res = '{valid: 1'b1, key_class: KC_PLAIN, key_byte: byte_i};
        end
      end
    end else if (opcode_i == OP_TIMEOUT) begin
      // timeout mid-sequence gives up on it
      state_d = idle_st;
      res     = lone_esc;
    end else begin
      unique case (state_q.phase)
        PH_ESC: begin
          state_d.first_was_bracket = (byte_i == ChLBracket);
          state_d.phase             = PH_SECOND;
        end
        PH_SECOND: begin
          if (!state_q.first_was_bracket) begin
            state_d = idle_st;
            res     = lone_esc;
          end else if (byte_i == ChOne) begin
            state_d.phase = PH_THIRD;
          end else if (byte_i >= ChZero && byte_i <= ChNine) begin
            state_d.digit_was_three = (byte_i == ChThree);
            state_d.phase           = PH_TILDE;
          end else if (arrow == KC_PLAIN) begin
            state_d = idle_st;
            res     = lone_esc;
          end else begin
            state_d = idle_st;
            res     = '{valid: 1'b1, key_class: arrow, key_byte: 8'd0};
          end
        end
        PH_THIRD: begin
          state_d.saw_semicolon = (byte_i == ChSemi);
          state_d.phase         = PH_FOURTH;
        end
        PH_FOURTH: begin
          if (state_q.saw_semicolon && byte_i == ChFive) begin
            state_d.phase = PH_FINAL;
          end else begin
            state_d = idle_st;
            res     = lone_esc;
          end
        end
        PH_FINAL: begin
          state_d = idle_st;
          if (arrow == KC_PLAIN) begin
            res = lone_esc;
          end else begin
            res = '{valid: 1'b1, key_class: key_class_e'(arrow + CtrlOffset),
                    key_byte: 8'd0};
          end
        end
        default: begin
          // waiting for the tilde of a numbered key
          state_d = idle_st;
          if (byte_i == ChTilde && state_q.digit_was_three) begin
            res = '{valid: 1'b1, key_class: KC_DELETE, key_byte: 8'd0};
          end else begin
            res = lone_esc;
          end
        end
      endcase
    end
  end

  assign result_o = res;
  assign state_o  = state_q;

endmodule

### design/terminal_key_escape_decoder_unit.sv
// Decodes terminal input words (received bytes, or timeout ticks flagged on
// s_axis_tuser_i) into keys: plain bytes, arrows, ctrl-arrows and delete.
// Unrecognised sequences and timeouts mid-sequence give a lone ESC key
// (class plain, byte 27). One word is taken every cycle while the output is
// not stalled. A key is offered once its closing word has been accepted:
// the word sits in the input register while the parser works on it, and the
// key lands in the result register when the word steps on. The parser state
// is registered and advances with each word that steps. Words that only
// advance a sequence produce no output.
module terminal_key_escape_decoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] byte_in
  input  logic       s_axis_tuser_i,   // [0] opcode
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] key_byte
  output logic [3:0] m_axis_tuser_o    // [3:0] key_class
);
  import tked_pkg::*;

  logic         in_valid_q;
  opcode_e      in_op_q;
  logic [7:0]   in_byte_q;
  logic         out_valid_q;
  key_class_e   out_class_q;
  logic [7:0]   out_byte_q;
  logic         step;
  key_result_t  res;
  parse_state_t pstate;

  // a word moves on when the result register is free or being emptied
  assign step            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || step;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_op_q   <= opcode_e'(s_axis_tuser_i);
      in_byte_q <= s_axis_tdata_i;
    end
  end

  // escape parser
  tked_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .opcode_i (in_op_q),
    .byte_i   (in_byte_q),
    .result_o (res),
    .state_o  (pstate)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (m_axis_tready_i || !out_valid_q) begin
      out_valid_q <= step && res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res.valid) begin
      out_class_q <= res.key_class;
      out_byte_q  <= res.key_byte;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tuser_o  = out_class_q;

  // only plain keys carry a byte value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != KC_PLAIN) |-> m_axis_tdata_o == 8'd0)
    else $error("non-plain key with nonzero byte");

  // a timeout while idle leaves no key and no state change
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && in_op_q == OP_TIMEOUT && pstate.phase == PH_IDLE)
      |-> !res.valid)
    else $error("idle timeout produced a key");

  // named keys only come from a closing phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && res.valid && res.key_class != KC_PLAIN) |->
      (pstate.phase == PH_SECOND || pstate.phase == PH_FINAL ||
       pstate.phase == PH_TILDE))
    else $error("named key from an unexpected phase");

  // a stalled result blocks the parser
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |=> $stable(pstate))
    else $error("parser advanced while output stalled");

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import tked_pkg::*;

  localparam int unsigned NumWords   = 1250;
  localparam int unsigned IdlePct    = 14;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainWait  = 8;

  // one input word, with a flag that holds it back until all keys are out
  typedef struct packed {
    logic       hold;
    opcode_e    op;
    logic [7:0] val;
  } word_t;

  // one decoded key
  typedef struct packed {
    key_class_e cls;
    logic [7:0] kbyte;
  } key_t;

  logic       clk_i    = 1'b0;
  logic       rst_ni   = 1'b0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;
  logic       s_tuser  = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [3:0] m_tuser;

  word_t       word_q[$];
  key_t        key_q[$];
  logic [7:0]  seq_q[$];
  word_t       cur_word;
  logic        hold_next = 1'b0;
  logic        steady    = 1'b0;
  int unsigned word_cnt  = 0;
  int unsigned words_total = 0;
  int unsigned words_sent  = 0;
  int unsigned errors      = 0;
  int unsigned cycles      = 0;

  // shadow copy of the parser state
  phase_e dec_phase   = PH_IDLE;
  logic   dec_bracket = 1'b0;
  logic   dec_semi    = 1'b0;
  logic   dec_three   = 1'b0;

  terminal_key_escape_decoder_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // final letter of an arrow sequence
  function automatic key_class_e final_letter(input logic [7:0] b);
    key_class_e k;
    case (b)
      ChUpperA: k = KC_UP;
      ChUpperB: k = KC_DOWN;
      ChUpperC: k = KC_RIGHT;
      ChUpperD: k = KC_LEFT;
      default:  k = KC_PLAIN;
    endcase
    return k;
  endfunction

  // queue a key and drop back to idle
  task automatic emit_key(input key_class_e k, input logic [7:0] b);
    key_t e;
    e.cls   = k;
    e.kbyte = b;
    key_q.push_back(e);
    dec_phase   = PH_IDLE;
    dec_bracket = 1'b0;
    dec_semi    = 1'b0;
    dec_three   = 1'b0;
  endtask

  // advance the shadow parser by one accepted word
  task automatic decode_word(input word_t w);
    key_class_e k;
    k = final_letter(w.val);
    if (dec_phase == PH_IDLE) begin
      if (w.op == OP_BYTE) begin
        if (w.val == ChEsc) dec_phase = PH_ESC;
        else emit_key(KC_PLAIN, w.val);
      end
    end else if (w.op == OP_TIMEOUT) begin
      emit_key(KC_PLAIN, ChEsc);
    end else begin
      case (dec_phase)
        PH_ESC: begin
          dec_bracket = (w.val == ChLBracket);
          dec_phase   = PH_SECOND;
        end
        PH_SECOND: begin
          if (!dec_bracket) begin
            emit_key(KC_PLAIN, ChEsc);
          end else if (w.val == ChOne) begin
            dec_phase = PH_THIRD;
          end else if (w.val >= ChZero && w.val <= ChNine) begin
            dec_three = (w.val == ChThree);
            dec_phase = PH_TILDE;
          end else if (k == KC_PLAIN) begin
            emit_key(KC_PLAIN, ChEsc);
          end else begin
            emit_key(k, 8'h00);
          end
        end
        PH_THIRD: begin
          dec_semi  = (w.val == ChSemi);
          dec_phase = PH_FOURTH;
        end
        PH_FOURTH: begin
          if (dec_semi && w.val == ChFive) dec_phase = PH_FINAL;
          else emit_key(KC_PLAIN, ChEsc);
        end
        PH_FINAL: begin
          if (k == KC_PLAIN) emit_key(KC_PLAIN, ChEsc);
          else emit_key(key_class_e'(k + CtrlOffset), 8'h00);
        end
        default: begin
          if (w.val == ChTilde && dec_three) emit_key(KC_DELETE, 8'h00);
          else emit_key(KC_PLAIN, ChEsc);
        end
      endcase
    end
  endtask

  // stimulus helpers
  task automatic add_word(input opcode_e op, input logic [7:0] v, input bit counted);
    word_t w;
    w.hold    = hold_next;
    w.op      = op;
    w.val     = v;
    hold_next = 1'b0;
    word_q.push_back(w);
    if (counted) word_cnt++;
  endtask

  task automatic add_text(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
                          input int unsigned n);
    logic [7:0] b[3];
    b = '{b0, b1, b2};
    for (int i = 0; i < n; i++) add_word(OP_BYTE, b[i], 1'b1);
  endtask

  // build a well-formed escape sequence in seq_q
  task automatic build_seq(input int unsigned kind);
    logic [7:0] letter;
    letter = ChUpperA + 8'($urandom_range(3));
    seq_q.delete();
    seq_q.push_back(ChEsc);
    seq_q.push_back(ChLBracket);
    case (kind)
      0: seq_q.push_back(letter);
      1: begin
        seq_q.push_back(ChOne);
        seq_q.push_back(ChSemi);
        seq_q.push_back(ChFive);
        seq_q.push_back(letter);
      end
      2: begin
        seq_q.push_back(ChThree);
        seq_q.push_back(ChTilde);
      end
      default: begin
        seq_q.push_back(ChZero + 8'($urandom_range(9)));
        seq_q.push_back(ChTilde);
      end
    endcase
  endtask

  task automatic send_seq();
    foreach (seq_q[i]) add_word(OP_BYTE, seq_q[i], 1'b1);
  endtask

  // stimulus, reset and end of run
  initial begin
    int unsigned pick;
    int unsigned pos;
    int unsigned next_hold;
    next_hold = 400;

    // directed: extremes, the arrow, ctrl-arrow and delete forms and the odd cases
    add_word(OP_BYTE, 8'h00, 1'b1);
    add_word(OP_BYTE, 8'hff, 1'b1);
    add_word(OP_TIMEOUT, 8'haa, 1'b1);
    add_text(ChEsc, ChLBracket, ChUpperA, 3);
    add_text(ChEsc, ChLBracket, ChOne, 3);
    add_text(ChSemi, ChFive, ChUpperD, 3);
    add_text(ChEsc, ChLBracket, ChThree, 3);
    add_word(OP_BYTE, ChTilde, 1'b1);
    // timeout straight after the escape
    add_word(OP_BYTE, ChEsc, 1'b1);
    add_word(OP_TIMEOUT, 8'h55, 1'b1);
    // first byte not a bracket, judged on the second
    add_text(ChEsc, 8'h4f, ChUpperA, 3);
    // escape inside a sequence is just another byte
    add_text(ChEsc, ChLBracket, ChEsc, 3);

    // random: a mix of well-formed sequences, plain bytes, timeouts and broken ones
    while (word_cnt < NumWords) begin
      if (word_cnt >= next_hold) begin
        hold_next = 1'b1;
        next_hold += 450;
      end
      pick = $urandom_range(99);
      if (pick < 25) begin
        add_word(OP_BYTE, 8'($urandom_range(255)), 1'b1);
      end else if (pick < 32) begin
        add_word(OP_TIMEOUT, 8'($urandom_range(255)), 1'b0);
      end else if (pick < 75) begin
        build_seq($urandom_range(3));
        send_seq();
      end else begin
        build_seq($urandom_range(3));
        pos = $urandom_range(seq_q.size() - 1, 1);
        case ($urandom_range(2))
          0: begin
            seq_q[pos] = ($urandom_range(3) == 0) ? ChEsc : 8'($urandom_range(255));
            send_seq();
          end
          1: begin
            while (seq_q.size() > pos) void'(seq_q.pop_back());
            send_seq();
            add_word(OP_TIMEOUT, 8'($urandom_range(255)), 1'b1);
          end
          default: begin
            while (seq_q.size() > pos) void'(seq_q.pop_back());
            send_seq();
          end
        endcase
      end
    end
    words_total = word_q.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (words_sent != words_total) @(posedge clk_i);
    while (key_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // word driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_p
    logic present;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'h00;
      s_tuser  <= 1'b0;
      steady   <= 1'b0;
    end else begin
      present = 1'b0;
      if (s_tvalid && s_tready) begin
        decode_word(cur_word);
        words_sent++;
      end
      steady <= (words_sent >= 250 && words_sent < 600);
      if (!s_tvalid || s_tready) begin
        if (word_q.size() != 0 && !(word_q[0].hold && key_q.size() != 0) &&
            (steady || $urandom_range(99) >= IdlePct)) begin
          cur_word = word_q.pop_front();
          present  = 1'b1;
        end
        s_tvalid <= present;
        if (present) begin
          s_tdata <= cur_word.val;
          s_tuser <= cur_word.op;
        end
      end
    end
  end

  // key monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin : watch_p
    key_t want;
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (key_q.size() == 0) begin
          $display("%0t: unexpected key, expected none, got class %0d byte %02h",
                   $time, m_tuser, m_tdata);
          errors++;
        end else begin
          want = key_q.pop_front();
          if (m_tuser !== want.cls) begin
            $display("%0t: key class expected %0d, got %0d", $time, want.cls, m_tuser);
            errors++;
          end
          if (m_tdata !== want.kbyte) begin
            $display("%0t: key byte expected %02h, got %02h", $time, want.kbyte, m_tdata);
            errors++;
          end
        end
      end
      m_tready <= steady || ($urandom_range(99) >= IdlePct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("testbench: errors");
      $finish;
    end
  end

endmodule
